### src/apc_pkg.sv
// ============================================================================
// apc_pkg
// Shared types and constants of the ARGB pixel combine block.
// ============================================================================
package apc_pkg;

    // Channel and gain widths
    localparam int CHAN_W   = 8;
    localparam int GAIN_W   = 9;
    localparam int ACT_W    = 3;
    localparam int NUM_CHAN = 4;
    localparam int CFG_IDX_W = 3;

    // Largest channel value, used by the saturating add
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // Gain reset value: 1.0 in unsigned 1.8 fixed point
    localparam logic [GAIN_W-1:0] GAIN_ONE = 9'h100;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_CONST_MOD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PIXEL_MOD = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SAT_ADD   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_COPY      = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE  = 3'd3;

    // One result pixel, alpha first
    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

endpackage

### src/apc_if.sv
// ============================================================================
// apc_if
// Valid/ready channels of the ARGB pixel combine block: the input word
// (action plus destination and source pixels) and the result pixel word.
// ============================================================================
interface apc_in_if;
    logic                        valid;
    logic                        ready;
    logic [apc_pkg::ACT_W-1:0]   action;
    logic [apc_pkg::CHAN_W-1:0]  dst_alpha;
    logic [apc_pkg::CHAN_W-1:0]  dst_red;
    logic [apc_pkg::CHAN_W-1:0]  dst_green;
    logic [apc_pkg::CHAN_W-1:0]  dst_blue;
    logic [apc_pkg::CHAN_W-1:0]  src_alpha;
    logic [apc_pkg::CHAN_W-1:0]  src_red;
    logic [apc_pkg::CHAN_W-1:0]  src_green;
    logic [apc_pkg::CHAN_W-1:0]  src_blue;

    modport source (
        output valid, action, dst_alpha, dst_red, dst_green, dst_blue,
               src_alpha, src_red, src_green, src_blue,
        input  ready
    );
    modport sink (
        input  valid, action, dst_alpha, dst_red, dst_green, dst_blue,
               src_alpha, src_red, src_green, src_blue,
        output ready
    );
endinterface

interface apc_out_if;
    logic                        valid;
    logic                        ready;
    logic [apc_pkg::CHAN_W-1:0]  out_alpha;
    logic [apc_pkg::CHAN_W-1:0]  out_red;
    logic [apc_pkg::CHAN_W-1:0]  out_green;
    logic [apc_pkg::CHAN_W-1:0]  out_blue;

    modport source (
        output valid, out_alpha, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, out_alpha, out_red, out_green, out_blue,
        output ready
    );
endinterface

### src/apc_lane.sv
// ============================================================================
// apc_lane
// One channel of the pixel combine: modulate, saturating add, clear, copy.
// ============================================================================
module apc_lane (
    input  logic [apc_pkg::ACT_W-1:0]  i_action,
    input  logic [apc_pkg::CHAN_W-1:0] i_dst,
    input  logic [apc_pkg::CHAN_W-1:0] i_src,
    input  logic [apc_pkg::GAIN_W-1:0] i_gain,
    output logic [apc_pkg::CHAN_W-1:0] o_result
);

    logic [apc_pkg::GAIN_W-1:0]                 mult_b;
    logic [apc_pkg::CHAN_W+apc_pkg::GAIN_W-1:0] product;
    logic [apc_pkg::CHAN_W:0]                   sum;
    logic [apc_pkg::CHAN_W-1:0]                 sat_sum;

    // Both modulate actions share one multiplier; only the second operand differs.
    assign mult_b  = (i_action == apc_pkg::ACT_CONST_MOD) ? i_gain
                                                          : {1'b0, i_src};
    assign product = {{apc_pkg::GAIN_W{1'b0}}, i_dst} *
                     {{apc_pkg::CHAN_W{1'b0}}, mult_b};

    // Saturating add clamps at the channel maximum.
    assign sum     = {1'b0, i_dst} + {1'b0, i_src};
    assign sat_sum = sum[apc_pkg::CHAN_W] ? apc_pkg::CHAN_MAX
                                          : sum[apc_pkg::CHAN_W-1:0];

    // Select the result; unused codes pass the destination through.
    always_comb begin
        case (i_action)
            apc_pkg::ACT_CONST_MOD,
            apc_pkg::ACT_PIXEL_MOD: o_result = product[2*apc_pkg::CHAN_W-1:apc_pkg::CHAN_W];
            apc_pkg::ACT_SAT_ADD:   o_result = sat_sum;
            apc_pkg::ACT_CLEAR:     o_result = '0;
            apc_pkg::ACT_COPY:      o_result = i_src;
            default:                o_result = i_dst;
        endcase
    end

endmodule

### src/apc_merge.sv
// ============================================================================
// apc_merge
// Gathers the four lane results into one pixel word and holds it in the
// output register until the receiver takes it.
// ============================================================================
module apc_merge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [apc_pkg::CHAN_W-1:0]   i_lane [apc_pkg::NUM_CHAN],
    output logic                         o_valid,
    input  logic                         i_ready,
    output apc_pkg::t_pixel              o_pixel
);

    logic            r_valid;
    logic            n_valid;
    apc_pkg::t_pixel r_pixel;
    logic            load;

    // The register takes a new word when empty or when its word leaves now.
    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;
    assign n_valid = load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register, lanes packed alpha first.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel <= '{alpha: i_lane[0], red: i_lane[1],
                         green: i_lane[2], blue: i_lane[3]};
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

### src/argb_pixel_combine.sv
// ============================================================================
// argb_pixel_combine
// ARGB pixel combine unit: constant or pixel modulate, saturating add, clear
// and copy over the four channels of one pixel.
// ============================================================================
// Usage:
//   Input channel i_in carries one word: an action, a destination pixel and
//   a source pixel. Output channel o_out carries the resulting pixel. Both
//   are valid/ready; a word moves when valid and ready are both high.
//   Four channel lanes work side by side on the accepted word and the
//   result is registered, so a result is presented in the cycle after its
//   word is accepted. One word is taken every cycle while the receiver
//   keeps ready high; the single output register sets that figure.
//   When the receiver stalls, the output word holds and i_in.ready drops
//   only while the register is full and not being emptied.
//   The gain registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data; indexes beyond the blue gain are ignored. Write them only
//   while no word is in flight.
//   Synchronous reset empties the output register and sets all gains to
//   1.0 (256 in unsigned 1.8).
// ============================================================================
module argb_pixel_combine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [apc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [apc_pkg::GAIN_W-1:0]     i_cfg_data,
    apc_in_if.sink                         i_in,
    apc_out_if.source                      o_out
);

    logic [apc_pkg::GAIN_W-1:0] r_gain [apc_pkg::NUM_CHAN];
    logic [apc_pkg::CHAN_W-1:0] dst    [apc_pkg::NUM_CHAN];
    logic [apc_pkg::CHAN_W-1:0] src    [apc_pkg::NUM_CHAN];
    logic [apc_pkg::CHAN_W-1:0] lane   [apc_pkg::NUM_CHAN];
    apc_pkg::t_pixel            pixel;

    // Gain registers, one per channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < apc_pkg::NUM_CHAN; k++) begin
                r_gain[k] <= apc_pkg::GAIN_ONE;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                apc_pkg::REG_GAIN_ALPHA: r_gain[0] <= i_cfg_data;
                apc_pkg::REG_GAIN_RED:   r_gain[1] <= i_cfg_data;
                apc_pkg::REG_GAIN_GREEN: r_gain[2] <= i_cfg_data;
                apc_pkg::REG_GAIN_BLUE:  r_gain[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Spread the input word over the lanes, alpha first.
    assign dst[0] = i_in.dst_alpha;
    assign dst[1] = i_in.dst_red;
    assign dst[2] = i_in.dst_green;
    assign dst[3] = i_in.dst_blue;
    assign src[0] = i_in.src_alpha;
    assign src[1] = i_in.src_red;
    assign src[2] = i_in.src_green;
    assign src[3] = i_in.src_blue;

    // Channel lanes.
    for (genvar g = 0; g < apc_pkg::NUM_CHAN; g++) begin : g_lane
        apc_lane u_lane (
            .i_action (i_in.action),
            .i_dst    (dst[g]),
            .i_src    (src[g]),
            .i_gain   (r_gain[g]),
            .o_result (lane[g])
        );
    end

    // Merge and output register.
    apc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_lane  (lane),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_pixel (pixel)
    );

    assign o_out.out_alpha = pixel.alpha;
    assign o_out.out_red   = pixel.red;
    assign o_out.out_green = pixel.green;
    assign o_out.out_blue  = pixel.blue;

endmodule
